[hw/rtl/tcw_pkg.sv]
// Shared constants for the text console writer.
package tcw_pkg;

    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;

    localparam int CMD_W   = 2;
    localparam int CHAR_W  = 8;
    localparam int ADDR_W  = 11;
    localparam int DATA_W  = 16;
    localparam int OCOL_W  = 7;
    localparam int OLINE_W = 5;
    localparam int OPOS_W  = 11;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;

    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    localparam logic [7:0] ATTR_RESET = 8'h04;

    localparam int          PADDR_W        = 3;
    localparam logic [2:0]  ADDR_TEXT_ATTR = 3'h0;

endpackage

[hw/rtl/tcw_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

[hw/rtl/text_console_writer.sv]
// Text console writer: screen memory, cursor and command sequencer.
// Every item passes S_EXEC and S_DONE; a cell read also passes S_READ, and a printable
// character or a tab passes S_CHAR, which writes one space per step for a tab. A newline on
// the last line scrolls the screen through the single RAM port pair in S_SCROLL and
// S_CLRROW, then writes the character when a wrap caused it; a clear runs S_FILL. The next
// item is taken only after the result of the last one has issued. After reset a clearing
// pass runs with s_tready low.
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // cmd[1:0], char_code[9:2], cell_address[20:10]
    input  logic [tcw_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // read_data[15:0], cursor_column[22:16], cursor_line[27:23], cursor_position[38:28]
    output logic [tcw_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcw_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int COPY_COUNT = CELL_COUNT - COLUMNS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int PW         = $clog2(CELL_COUNT + 1);
    localparam int COL_W      = $clog2(COLUMNS + 1);
    localparam int LINE_W     = $clog2(ROWS);

    typedef enum logic [8:0] {
        S_INIT   = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_EXEC   = 9'b000000100,
        S_READ   = 9'b000001000,
        S_CHAR   = 9'b000010000,
        S_SCROLL = 9'b000100000,
        S_CLRROW = 9'b001000000,
        S_FILL   = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [7:0]                    attr_reg;
    logic [tcw_pkg::CMD_W-1:0]     cmd_reg, cmd_next;
    logic [tcw_pkg::CHAR_W-1:0]    code_reg, code_next;
    logic [tcw_pkg::ADDR_W-1:0]    addr_reg, addr_next;
    logic [COL_W-1:0]              col_reg, col_next;
    logic [LINE_W-1:0]             line_reg, line_next;
    logic [AW-1:0]                 base_reg, base_next;
    logic [AW-1:0]                 idx_reg, idx_next;
    logic                          ret_char_reg, ret_char_next;
    logic [tcw_pkg::DATA_W-1:0]    rdata_reg, rdata_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [tcw_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [tcw_pkg::DATA_W-1:0] ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [tcw_pkg::DATA_W-1:0] ram_rdata;

    logic [PW-1:0]    pos_sum;
    logic [COL_W-1:0] col_inc;
    logic             cfg_write;

    tcw_ram #(
        .WIDTH (tcw_pkg::DATA_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pos_sum = PW'(base_reg) + PW'(col_reg);
    assign col_inc = col_reg + 1'b1;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == tcw_pkg::ADDR_TEXT_ATTR[2]);
    assign prdata    = (paddr[2] == tcw_pkg::ADDR_TEXT_ATTR[2]) ? {24'd0, attr_reg} : 32'd0;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        code_next     = code_reg;
        addr_next     = addr_reg;
        col_next      = col_reg;
        line_next     = line_reg;
        base_next     = base_reg;
        idx_next      = idx_reg;
        ret_char_next = ret_char_reg;
        rdata_next    = rdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        ram_we        = 1'b0;
        ram_waddr     = AW'(pos_sum);
        ram_wdata     = {attr_reg, tcw_pkg::CHAR_SPACE};
        ram_raddr     = '0;

        unique case (state_reg)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = {tcw_pkg::ATTR_RESET, tcw_pkg::CHAR_SPACE};
                if (idx_reg == AW'(CELL_COUNT - 1)) begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = s_tdata[1:0];
                    code_next  = s_tdata[9:2];
                    addr_next  = s_tdata[20:10];
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                rdata_next = '0;
                state_next = S_DONE;
                case (cmd_reg)
                    tcw_pkg::CMD_READ: begin
                        if (int'(addr_reg) < CELL_COUNT) begin
                            ram_raddr  = AW'(addr_reg);
                            state_next = S_READ;
                        end
                    end
                    tcw_pkg::CMD_CLEAR: begin
                        idx_next   = '0;
                        state_next = S_FILL;
                    end
                    tcw_pkg::CMD_PUT: begin
                        if (code_reg == tcw_pkg::CHAR_CR) begin
                            col_next = '0;
                        end else if (code_reg == tcw_pkg::CHAR_BS) begin
                            if (col_reg != '0 || line_reg != '0) begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(pos_sum - 1'b1);
                                if (col_reg == '0) begin
                                    line_next = line_reg - 1'b1;
                                    base_next = base_reg - AW'(COLUMNS);
                                    col_next  = COL_W'(COLUMNS - 1);
                                end else begin
                                    col_next = col_reg - 1'b1;
                                end
                            end
                        end else if (code_reg == tcw_pkg::CHAR_NL
                                     || col_reg == COL_W'(COLUMNS)) begin
                            ret_char_next = (code_reg != tcw_pkg::CHAR_NL);
                            col_next      = '0;
                            if (line_reg != LINE_W'(ROWS - 1)) begin
                                line_next  = line_reg + 1'b1;
                                base_next  = base_reg + AW'(COLUMNS);
                                state_next = (code_reg != tcw_pkg::CHAR_NL) ? S_CHAR : S_DONE;
                            end else begin
                                idx_next   = '0;
                                state_next = S_SCROLL;
                            end
                        end else begin
                            state_next = S_CHAR;
                        end
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_READ: begin
                rdata_next = ram_rdata;
                state_next = S_DONE;
            end
            S_CHAR: begin
                ram_we   = 1'b1;
                col_next = col_inc;
                if (code_reg == tcw_pkg::CHAR_TAB) begin
                    if (col_inc[1:0] == 2'b00 || col_inc == COL_W'(COLUMNS)) begin
                        state_next = S_DONE;
                    end
                end else begin
                    ram_wdata  = {attr_reg, code_reg};
                    state_next = S_DONE;
                end
            end
            S_SCROLL: begin
                if (idx_reg != AW'(COPY_COUNT)) begin
                    ram_raddr = idx_reg + AW'(COLUMNS);
                end
                if (idx_reg != '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_reg - 1'b1;
                    ram_wdata = ram_rdata;
                end
                if (idx_reg == AW'(COPY_COUNT)) begin
                    state_next = S_CLRROW;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_CLRROW: begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                if (idx_reg == AW'(CELL_COUNT - 1)) begin
                    state_next = ret_char_reg ? S_CHAR : S_DONE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                if (idx_reg == AW'(CELL_COUNT - 1)) begin
                    col_next   = '0;
                    line_next  = '0;
                    base_next  = '0;
                    state_next = S_DONE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0,
                                     tcw_pkg::OPOS_W'(pos_sum),
                                     tcw_pkg::OLINE_W'(line_reg),
                                     tcw_pkg::OCOL_W'(col_reg),
                                     rdata_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT;
            attr_reg     <= tcw_pkg::ATTR_RESET;
            col_reg      <= '0;
            line_reg     <= '0;
            base_reg     <= '0;
            idx_reg      <= '0;
            ret_char_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            col_reg      <= col_next;
            line_reg     <= line_next;
            base_reg     <= base_next;
            idx_reg      <= idx_next;
            ret_char_reg <= ret_char_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_write) begin
                attr_reg <= pwdata[7:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        code_reg    <= code_next;
        addr_reg    <= addr_next;
        rdata_reg   <= rdata_next;
        m_tdata_reg <= m_tdata_next;
    end

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        int'(base_reg) == int'(line_reg) * COLUMNS)
        else $error("Line base address does not match the cursor line.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        int'(col_reg) <= COLUMNS && int'(line_reg) < ROWS)
        else $error("Cursor left the screen.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("A new item was taken while one is still in work.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && m_tvalid_reg && !m_tready) |=> state_reg == S_DONE)
        else $error("A result was dropped while the output was stalled.");
`endif

endmodule

[dv/testbench.sv]
// Self-checking testbench for the text console writer: screen, cursor and attribute register.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int COLS        = COLUMNS_DEFAULT;
    localparam int ROWS        = ROWS_DEFAULT;
    localparam int CELLS       = COLS * ROWS;
    localparam int TAB_STOP    = 4;
    localparam int CYCLE_LIMIT = 5_000_000;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic [OCOL_W-1:0]  cursor_column;
        logic [OLINE_W-1:0] cursor_row;
        logic [OPOS_W-1:0]  cursor_position;
    } console_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [31:0]          pwdata   = '0;
    logic [31:0]          prdata;
    logic                 pready;

    logic [15:0] screen_mem [CELLS];
    int          cur_col;
    int          cur_line;
    logic [7:0]  text_attr;

    console_result_t pending_results[$];
    int              mismatches      = 0;
    int              items_sent      = 0;
    int              results_checked = 0;
    int              scroll_count    = 0;
    int              read_count      = 0;
    int              cycle_count     = 0;
    int              stall_left      = 0;
    bit              calm_tail       = 1'b0;

    text_console_writer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic void report_mismatch(string what);
        mismatches++;
        if (mismatches <= 10) $display("Mismatch at %0t: %s", $realtime, what);
    endfunction

    // Screen and cursor predictor.
    function automatic void store_cell(int row, int col, logic [7:0] code);
        if (row < ROWS && col < COLS) screen_mem[row * COLS + col] = {text_attr, code};
    endfunction

    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++) screen_mem[i] = {text_attr, CHAR_SPACE};
    endfunction

    function automatic void advance_line();
        if (cur_line < ROWS - 1) begin
            cur_line++;
        end else begin
            for (int i = COLS; i < CELLS; i++) screen_mem[i - COLS] = screen_mem[i];
            for (int i = 0; i < COLS; i++) store_cell(ROWS - 1, i, CHAR_SPACE);
            scroll_count++;
        end
        cur_col = 0;
    endfunction

    function automatic void put_character(logic [7:0] c);
        int n;
        case (c)
            CHAR_NL: advance_line();
            CHAR_CR: cur_col = 0;
            CHAR_BS: begin
                if (cur_col != 0 || cur_line != 0) begin
                    if (cur_col == 0) begin
                        cur_line--;
                        cur_col = COLS;
                    end
                    cur_col--;
                    store_cell(cur_line, cur_col, CHAR_SPACE);
                end
            end
            CHAR_TAB: begin
                if (cur_col >= COLS) advance_line();
                n = TAB_STOP - (cur_col % TAB_STOP);
                while (n != 0 && cur_col < COLS) begin
                    store_cell(cur_line, cur_col, CHAR_SPACE);
                    cur_col++;
                    n--;
                end
            end
            default: begin
                if (cur_col >= COLS) advance_line();
                store_cell(cur_line, cur_col, c);
                cur_col++;
            end
        endcase
    endfunction

    function automatic console_result_t console_step(logic [CMD_W-1:0] cmd,
                                                     logic [CHAR_W-1:0] ch,
                                                     logic [ADDR_W-1:0] addr);
        console_result_t r;
        r.read_data = '0;
        case (cmd)
            CMD_PUT:  put_character(ch);
            CMD_READ: begin
                read_count++;
                if (addr < CELLS) r.read_data = screen_mem[addr];
            end
            CMD_CLEAR: begin
                blank_screen();
                cur_col  = 0;
                cur_line = 0;
            end
            default: ;
        endcase
        r.cursor_column   = OCOL_W'(cur_col);
        r.cursor_row      = OLINE_W'(cur_line);
        r.cursor_position = OPOS_W'(cur_line * COLS + cur_col);
        return r;
    endfunction

    // Result side: random stall bursts, then compare against the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        console_result_t want;
        console_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.read_data       = m_tdata[15:0];
            got.cursor_column   = m_tdata[22:16];
            got.cursor_row      = m_tdata[27:23];
            got.cursor_position = m_tdata[38:28];
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected item %h", m_tdata));
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (got !== want)
                    report_mismatch($sformatf(
                        "data %h/%h col %0d/%0d line %0d/%0d pos %0d/%0d (expected/actual)",
                        want.read_data, got.read_data, want.cursor_column, got.cursor_column,
                        want.cursor_row, got.cursor_row, want.cursor_position,
                        got.cursor_position));
            end
        end
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                             input logic [ADDR_W-1:0] addr);
        int gap;
        gap = 0;
        if (!calm_tail && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {3'b000, addr, ch, cmd};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(console_step(cmd, ch, addr));
        items_sent++;
    endtask

    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_text_attribute(input logic [7:0] value);
        logic [31:0] readback;
        settle_idle();
        apb_access(1'b1, ADDR_TEXT_ATTR, {24'h0, value}, readback);
        text_attr = value;
        apb_access(1'b0, ADDR_TEXT_ATTR, 32'h0, readback);
        if (readback[7:0] !== value)
            report_mismatch($sformatf("attribute readback %h, expected %h",
                                      readback[7:0], value));
    endtask

    function automatic logic [ADDR_W-1:0] random_address();
        return ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
    endfunction

    function automatic logic [CHAR_W-1:0] random_text_char();
        if ($urandom_range(0, 7) == 0) return CHAR_TAB;
        if ($urandom_range(0, 9) == 0) return CHAR_W'($urandom_range(0, 255));
        return CHAR_W'($urandom_range(32, 126));
    endfunction

    task automatic test_reset_screen();
        send_item(CMD_READ, 8'h00, 11'd0);
        send_item(CMD_READ, 8'hFF, ADDR_W'(CELLS - 1));
        send_item(CMD_READ, 8'h00, ADDR_W'(CELLS));
        send_item(CMD_READ, 8'h00, 11'h7FF);
        send_item(CMD_UNUSED, 8'hFF, 11'h7FF);
        send_item(CMD_READ, 8'h00, ADDR_W'($urandom_range(0, CELLS - 1)));
    endtask

    task automatic test_control_chars();
        send_item(CMD_PUT, CHAR_BS, 11'd0);
        send_item(CMD_PUT, 8'h00, 11'h7FF);
        send_item(CMD_PUT, 8'hFF, 11'd0);
        send_item(CMD_READ, 8'h00, 11'd0);
        send_item(CMD_READ, 8'h00, 11'd1);
        send_item(CMD_PUT, CHAR_TAB, 11'd0);
        send_item(CMD_PUT, CHAR_CR, 11'd0);
        send_item(CMD_PUT, CHAR_NL, 11'd0);
        send_item(CMD_PUT, CHAR_BS, 11'd0);
        send_item(CMD_READ, 8'h00, ADDR_W'(COLS - 1));
        send_item(CMD_PUT, 8'h41, 11'd0);
        send_item(CMD_PUT, CHAR_TAB, 11'd0);
        send_item(CMD_READ, 8'h00, ADDR_W'(COLS));
        send_item(CMD_PUT, CHAR_BS, 11'd0);
        send_item(CMD_READ, 8'h00, ADDR_W'(COLS + 3));
        send_item(CMD_CLEAR, 8'h00, 11'd0);
        send_item(CMD_READ, 8'h00, ADDR_W'(COLS));
    endtask

    // Text bursts, line breaks, erases, reads, lone characters, unused commands and clears,
    // so that the cursor wraps at the line end and scrolling at the bottom happens often.
    task automatic test_random_text(input int item_goal);
        int sent;
        int kind;
        int len;
        int near;
        sent = 0;
        while (sent < item_goal) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                len = $urandom_range(1, 90);
                for (int i = 0; i < len; i++) send_item(CMD_PUT, random_text_char(),
                                                        random_address());
            end else if (kind < 55) begin
                len = (cur_line == ROWS - 1) ? $urandom_range(1, 4) : $urandom_range(1, 30);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 3) == 0) send_item(CMD_PUT, CHAR_CR, random_address());
                    send_item(CMD_PUT, CHAR_NL, random_address());
                end
            end else if (kind < 65) begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) send_item(CMD_PUT, CHAR_BS, random_address());
            end else if (kind < 85) begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    near = cur_line * COLS + cur_col - $urandom_range(0, 8);
                    if ($urandom_range(0, 2) == 0 || near < 0)
                        send_item(CMD_READ, random_text_char(), random_address());
                    else
                        send_item(CMD_READ, random_text_char(), ADDR_W'(near));
                end
            end else if (kind < 92) begin
                len = 1;
                send_item(CMD_PUT, CHAR_W'($urandom_range(0, 255)), random_address());
            end else if (kind < 96) begin
                len = 1;
                send_item(CMD_UNUSED, CHAR_W'($urandom_range(0, 255)), random_address());
            end else begin
                len = 1;
                send_item(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)), random_address());
            end
            sent += len;
        end
    endtask

    initial begin
        text_attr = ATTR_RESET;
        cur_col   = 0;
        cur_line  = 0;
        blank_screen();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_screen();
        set_text_attribute(8'hFF);
        test_control_chars();
        set_text_attribute(8'h00);
        test_random_text(150);
        set_text_attribute(8'($urandom_range(1, 254)));
        test_random_text(150);
        set_text_attribute(8'($urandom_range(0, 255)));
        calm_tail = 1'b1;
        test_random_text(100);

        settle_idle();
        repeat (20) @(posedge aclk);
        $display("Sent %0d items and checked %0d results, including %0d cell reads.",
                 items_sent, results_checked, read_count);
        $display("The screen scrolled %0d times under %0d attribute settings.",
                 scroll_count, 5);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches in total", mismatches);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
